### rtl/core/gbed_pkg.sv
package gbed_pkg;

  localparam int GBED_NUM_PINS = 54;

  localparam int FSEL_WORDS = 6;
  localparam int FSEL_PINS = 10;

  localparam logic [2:0] FSEL_OUTPUT = 3'b001;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } gbed_cmd_t;

  localparam logic [5:0] WORD_SET_LO = 6'd7;
  localparam logic [5:0] WORD_SET_HI = 6'd8;
  localparam logic [5:0] WORD_CLR_LO = 6'd10;
  localparam logic [5:0] WORD_CLR_HI = 6'd11;
  localparam logic [5:0] WORD_LEV_LO = 6'd13;
  localparam logic [5:0] WORD_LEV_HI = 6'd14;
  localparam logic [5:0] WORD_EDS_LO = 6'd16;
  localparam logic [5:0] WORD_EDS_HI = 6'd17;
  localparam logic [5:0] WORD_REN_LO = 6'd19;
  localparam logic [5:0] WORD_REN_HI = 6'd20;
  localparam logic [5:0] WORD_FEN_LO = 6'd22;
  localparam logic [5:0] WORD_FEN_HI = 6'd23;
  localparam logic [5:0] WORD_HEN_LO = 6'd25;
  localparam logic [5:0] WORD_HEN_HI = 6'd26;
  localparam logic [5:0] WORD_LEN_LO = 6'd28;
  localparam logic [5:0] WORD_LEN_HI = 6'd29;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] drive_low;
    logic [31:0] drive_high;
    logic [31:0] enable_low;
    logic [31:0] enable_high;
    logic        irq;
  } gbed_result_t;

endpackage

### rtl/core/gbed_core.sv
module gbed_core import gbed_pkg::*; #(
  parameter int NUM_PINS = GBED_NUM_PINS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  gbed_cmd_t    cmd,
  input  logic [5:0]   word_index,
  input  logic [31:0]  write_data,
  input  logic [31:0]  pins_low,
  input  logic [31:0]  pins_high,
  output gbed_result_t result
);

  logic [NUM_PINS-1:0][2:0] fsel, fsel_next;
  logic [NUM_PINS-1:0] latch, latch_next;
  logic [NUM_PINS-1:0] prev, prev_next;
  logic [NUM_PINS-1:0] status, status_next;
  logic [NUM_PINS-1:0] ren, ren_next;
  logic [NUM_PINS-1:0] fen, fen_next;
  logic [NUM_PINS-1:0] hen, hen_next;
  logic [NUM_PINS-1:0] len, len_next;
  logic [NUM_PINS-1:0] en_next;
  logic [NUM_PINS-1:0] now;
  logic [NUM_PINS-1:0] ev;

  logic [63:0][2:0] fsel64;
  logic [31:0] fsel_word [FSEL_WORDS];
  logic [63:0] wlo, whi;
  logic [63:0] latch_out, en_out;
  logic [31:0] rd;
  logic fsel_hit;

  assign wlo = {32'b0, write_data};
  assign whi = {write_data, 32'b0};
  assign fsel_hit = (cmd == CMD_WRITE) && (word_index < 6'(FSEL_WORDS));

  always_comb begin
    fsel64 = '0;
    fsel64[NUM_PINS-1:0] = fsel;
    for (int w = 0; w < FSEL_WORDS; w++) begin
      fsel_word[w] = {2'b0, fsel64[w*FSEL_PINS +: FSEL_PINS]};
    end
  end

  for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
    if (p < FSEL_WORDS * FSEL_PINS) begin : g_fsel
      assign fsel_next[p] = (fsel_hit && word_index == 6'(p / FSEL_PINS)) ?
                            write_data[3*(p % FSEL_PINS) +: 3] : fsel[p];
    end else begin : g_fixed
      assign fsel_next[p] = fsel[p];
    end
    assign en_next[p] = (fsel_next[p] == FSEL_OUTPUT);
  end

  assign now = NUM_PINS'({pins_high, pins_low});
  assign ev = (now & ~prev & ren) | (~now & prev & fen) | (now & hen) | (~now & len);

  always_comb begin
    latch_next = latch;
    prev_next = prev;
    status_next = status;
    ren_next = ren;
    fen_next = fen;
    hen_next = hen;
    len_next = len;
    rd = '0;
    unique case (cmd)
      CMD_READ: begin
        if (word_index < 6'(FSEL_WORDS)) begin
          rd = fsel_word[word_index[2:0]];
        end else begin
          unique case (word_index)
            WORD_LEV_LO: rd = 32'(64'(prev));
            WORD_LEV_HI: rd = 32'(64'(prev) >> 32);
            WORD_EDS_LO: rd = 32'(64'(status));
            WORD_EDS_HI: rd = 32'(64'(status) >> 32);
            WORD_REN_LO: rd = 32'(64'(ren));
            WORD_REN_HI: rd = 32'(64'(ren) >> 32);
            WORD_FEN_LO: rd = 32'(64'(fen));
            WORD_FEN_HI: rd = 32'(64'(fen) >> 32);
            WORD_HEN_LO: rd = 32'(64'(hen));
            WORD_HEN_HI: rd = 32'(64'(hen) >> 32);
            WORD_LEN_LO: rd = 32'(64'(len));
            WORD_LEN_HI: rd = 32'(64'(len) >> 32);
            default: rd = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        unique case (word_index)
          WORD_SET_LO: latch_next = latch | NUM_PINS'(wlo);
          WORD_SET_HI: latch_next = latch | NUM_PINS'(whi);
          WORD_CLR_LO: latch_next = latch & ~NUM_PINS'(wlo);
          WORD_CLR_HI: latch_next = latch & ~NUM_PINS'(whi);
          WORD_EDS_LO: status_next = status & ~NUM_PINS'(wlo);
          WORD_EDS_HI: status_next = status & ~NUM_PINS'(whi);
          WORD_REN_LO: ren_next = NUM_PINS'((64'(ren) & ~64'hFFFF_FFFF) | wlo);
          WORD_REN_HI: ren_next = NUM_PINS'((64'(ren) & 64'hFFFF_FFFF) | whi);
          WORD_FEN_LO: fen_next = NUM_PINS'((64'(fen) & ~64'hFFFF_FFFF) | wlo);
          WORD_FEN_HI: fen_next = NUM_PINS'((64'(fen) & 64'hFFFF_FFFF) | whi);
          WORD_HEN_LO: hen_next = NUM_PINS'((64'(hen) & ~64'hFFFF_FFFF) | wlo);
          WORD_HEN_HI: hen_next = NUM_PINS'((64'(hen) & 64'hFFFF_FFFF) | whi);
          WORD_LEN_LO: len_next = NUM_PINS'((64'(len) & ~64'hFFFF_FFFF) | wlo);
          WORD_LEN_HI: len_next = NUM_PINS'((64'(len) & 64'hFFFF_FFFF) | whi);
          default: ;
        endcase
      end
      CMD_TICK: begin
        status_next = status | ev;
        prev_next = now;
      end
      CMD_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsel <= '0;
      latch <= '0;
      prev <= '0;
      status <= '0;
      ren <= '0;
      fen <= '0;
      hen <= '0;
      len <= '0;
    end else if (step) begin
      fsel <= fsel_next;
      latch <= latch_next;
      prev <= prev_next;
      status <= status_next;
      ren <= ren_next;
      fen <= fen_next;
      hen <= hen_next;
      len <= len_next;
    end
  end

  assign latch_out = 64'(latch_next);
  assign en_out = 64'(en_next);

  always_comb begin
    result.read_data = rd;
    result.drive_low = latch_out[31:0];
    result.drive_high = latch_out[63:32];
    result.enable_low = en_out[31:0];
    result.enable_high = en_out[63:32];
    result.irq = |status_next;
  end

endmodule

### rtl/core/gpio_bank_with_event_detect.sv
// GPIO bank of NUM_PINS pins (1 to 64) behind 32-bit register words, with
// edge and level event detection on pin sample ticks. For every accepted word
// (bus read, bus write or sample tick) the pin registers update at the
// accepting edge and the result register holds read data, the output latch,
// the output enables and irq as they stand after that word.
// A new word is accepted in every cycle while the result register is empty
// or being taken, so the sustained rate is one word per clock; the result
// is valid in the cycle after acceptance.
module gpio_bank_with_event_detect import gbed_pkg::*; #(
  parameter int NUM_PINS = GBED_NUM_PINS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [5:0]  word_index,
  input  logic [31:0] write_data,
  input  logic [31:0] pins_low,
  input  logic [31:0] pins_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic [31:0] drive_low,
  output logic [31:0] drive_high,
  output logic [31:0] enable_low,
  output logic [31:0] enable_high,
  output logic        irq
);

  gbed_result_t result;
  gbed_result_t held;
  logic accept;

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  gbed_core #(.NUM_PINS(NUM_PINS)) u_core (
    .clk(clk),
    .rst(rst),
    .step(accept),
    .cmd(gbed_cmd_t'(cmd)),
    .word_index(word_index),
    .write_data(write_data),
    .pins_low(pins_low),
    .pins_high(pins_high),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && !out_ready);
    end
    if (accept) begin
      held <= result;
    end
  end

  assign read_data = held.read_data;
  assign drive_low = held.drive_low;
  assign drive_high = held.drive_high;
  assign enable_low = held.enable_low;
  assign enable_high = held.enable_high;
  assign irq = held.irq;

endmodule

### tb/tb_top.sv
module tb_top import gbed_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPINS = GBED_NUM_PINS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1750;

  class gpio_shadow;
    logic [2:0]   fsel [64];
    logic [63:0]  latch;
    logic [63:0]  level;
    logic [63:0]  status;
    logic [63:0]  rise_en;
    logic [63:0]  fall_en;
    logic [63:0]  high_en;
    logic [63:0]  low_en;
    gbed_result_t pending [$];
    int           errors;

    function new();
      foreach (fsel[p]) fsel[p] = '0;
      latch = '0;
      level = '0;
      status = '0;
      rise_en = '0;
      fall_en = '0;
      high_en = '0;
      low_en = '0;
      errors = 0;
    endfunction

    function logic [63:0] pin_mask();
      return (NPINS >= 64) ? '1 : ((64'd1 << NPINS) - 64'd1);
    endfunction

    function logic [31:0] half(logic [63:0] r, bit hi);
      return hi ? r[63:32] : r[31:0];
    endfunction

    function logic [63:0] spread(logic [31:0] d, bit hi);
      return hi ? {d, 32'h0} : {32'h0, d};
    endfunction

    function logic [63:0] put_half(logic [63:0] r, bit hi, logic [31:0] d);
      return (hi ? {d, r[31:0]} : {r[63:32], d}) & pin_mask();
    endfunction

    function logic [31:0] read_reg(logic [5:0] w);
      logic [31:0] v;
      int p;
      v = '0;
      if (w < FSEL_WORDS) begin
        for (int i = 0; i < FSEL_PINS; i++) begin
          p = w * FSEL_PINS + i;
          if (p < NPINS && p < 64) v[3*i +: 3] = fsel[p];
        end
        return v;
      end
      case (w)
        WORD_LEV_LO, WORD_LEV_HI: v = half(level, w == WORD_LEV_HI);
        WORD_EDS_LO, WORD_EDS_HI: v = half(status, w == WORD_EDS_HI);
        WORD_REN_LO, WORD_REN_HI: v = half(rise_en, w == WORD_REN_HI);
        WORD_FEN_LO, WORD_FEN_HI: v = half(fall_en, w == WORD_FEN_HI);
        WORD_HEN_LO, WORD_HEN_HI: v = half(high_en, w == WORD_HEN_HI);
        WORD_LEN_LO, WORD_LEN_HI: v = half(low_en, w == WORD_LEN_HI);
        default: v = '0;
      endcase
      return v;
    endfunction

    function void write_reg(logic [5:0] w, logic [31:0] d);
      int p;
      if (w < FSEL_WORDS) begin
        for (int i = 0; i < FSEL_PINS; i++) begin
          p = w * FSEL_PINS + i;
          if (p < NPINS && p < 64) fsel[p] = d[3*i +: 3];
        end
        return;
      end
      case (w)
        WORD_SET_LO, WORD_SET_HI:
          latch = (latch | spread(d, w == WORD_SET_HI)) & pin_mask();
        WORD_CLR_LO, WORD_CLR_HI: latch = latch & ~spread(d, w == WORD_CLR_HI);
        WORD_EDS_LO, WORD_EDS_HI: status = status & ~spread(d, w == WORD_EDS_HI);
        WORD_REN_LO, WORD_REN_HI: rise_en = put_half(rise_en, w == WORD_REN_HI, d);
        WORD_FEN_LO, WORD_FEN_HI: fall_en = put_half(fall_en, w == WORD_FEN_HI, d);
        WORD_HEN_LO, WORD_HEN_HI: high_en = put_half(high_en, w == WORD_HEN_HI, d);
        WORD_LEN_LO, WORD_LEN_HI: low_en = put_half(low_en, w == WORD_LEN_HI, d);
        default: ;
      endcase
    endfunction

    function void note_word(logic [1:0] c, logic [5:0] w, logic [31:0] d, logic [63:0] pins);
      gbed_result_t r;
      logic [63:0] now;
      logic [63:0] hit;
      logic [63:0] outs;
      r = '0;
      if (c == CMD_READ) begin
        r.read_data = read_reg(w);
      end else if (c == CMD_WRITE) begin
        write_reg(w, d);
      end else if (c == CMD_TICK) begin
        now = pins & pin_mask();
        hit = (now & ~level & rise_en) | (~now & level & fall_en) |
              (now & high_en) | (~now & low_en);
        status = (status | hit) & pin_mask();
        level = now;
      end
      outs = '0;
      for (int p = 0; p < NPINS && p < 64; p++) outs[p] = (fsel[p] == FSEL_OUTPUT);
      r.drive_low = latch[31:0];
      r.drive_high = latch[63:32];
      r.enable_low = outs[31:0];
      r.enable_high = outs[63:32];
      r.irq = (status != 0);
      pending.push_back(r);
    endfunction

    function void match(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(gbed_result_t got);
      gbed_result_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      want = pending.pop_front();
      match("read_data", want.read_data, got.read_data);
      match("drive_low", want.drive_low, got.drive_low);
      match("drive_high", want.drive_high, got.drive_high);
      match("enable_low", want.enable_low, got.enable_low);
      match("enable_high", want.enable_high, got.enable_high);
      match("irq", {31'h0, want.irq}, {31'h0, got.irq});
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  gbed_cmd_t   cmd = CMD_READ;
  logic [5:0]  word_index = '0;
  logic [31:0] write_data = '0;
  logic [31:0] pins_low = '0;
  logic [31:0] pins_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic [31:0] drive_low;
  logic [31:0] drive_high;
  logic [31:0] enable_low;
  logic [31:0] enable_high;
  logic        irq;

  gpio_shadow  sb = new();
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  logic [63:0] last_pins = '0;

  gpio_bank_with_event_detect dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .word_index(word_index), .write_data(write_data),
    .pins_low(pins_low), .pins_high(pins_high),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .drive_low(drive_low), .drive_high(drive_high),
    .enable_low(enable_low), .enable_high(enable_high), .irq(irq)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_word(cmd, word_index, write_data, {pins_high, pins_low});
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{read_data, drive_low, drive_high, enable_low, enable_high, irq});
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_word(gbed_cmd_t c, logic [5:0] w, logic [31:0] d, logic [63:0] pins);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd <= c;
    word_index <= w;
    write_data <= d;
    pins_low <= pins[31:0];
    pins_high <= pins[63:32];
    in_valid <= 1'b1;
    last_pins = pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic [31:0] pick_data(logic [5:0] w);
    int r;
    logic [31:0] d;
    r = $urandom_range(99);
    if (w < FSEL_WORDS && r < 40) begin
      d = $urandom;
      for (int i = 0; i < FSEL_PINS; i++)
        if ($urandom_range(1)) d[3*i +: 3] = FSEL_OUTPUT;
    end else if (r < 60) begin
      d = '0;
    end else if (r < 72) begin
      d = '1;
    end else if (r < 80) begin
      d = 32'h1 << $urandom_range(31);
    end else begin
      d = $urandom;
    end
    return d;
  endfunction

  function automatic logic [63:0] pick_pins();
    int r;
    r = $urandom_range(99);
    if (r < 30) return last_pins;
    if (r < 50) return last_pins ^ (64'h1 << $urandom_range(63));
    if (r < 55) return '1;
    if (r < 60) return '0;
    return {$urandom, $urandom};
  endfunction

  task automatic random_word();
    int r;
    gbed_cmd_t c;
    logic [5:0] w;
    r = $urandom_range(99);
    c = (r < 30) ? CMD_READ : (r < 65) ? CMD_WRITE : (r < 95) ? CMD_TICK : CMD_NOP;
    w = ($urandom_range(99) < 85) ? 6'($urandom_range(29)) : 6'($urandom_range(30, 63));
    send_word(c, w, (c == CMD_WRITE) ? pick_data(w) : 32'($urandom), pick_pins());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(CMD_READ, 6'd0, '0, '0);
    send_word(CMD_WRITE, 6'd0, 32'hC924_9249, '0);
    send_word(CMD_READ, 6'd0, '0, '0);
    send_word(CMD_WRITE, 6'd5, 32'hFFFF_FFFF, '0);
    send_word(CMD_READ, 6'd5, '0, '0);
    send_word(CMD_WRITE, 6'd5, 32'h0000_1249, '0);
    send_word(CMD_WRITE, WORD_SET_LO, 32'hFFFF_FFFF, '0);
    send_word(CMD_WRITE, WORD_SET_HI, 32'hFFFF_FFFF, '0);
    send_word(CMD_READ, WORD_SET_HI, '0, '0);
    send_word(CMD_WRITE, WORD_CLR_LO, 32'hAAAA_AAAA, '0);
    send_word(CMD_WRITE, WORD_REN_LO, 32'hFFFF_FFFF, '0);
    send_word(CMD_WRITE, WORD_FEN_HI, 32'hFFFF_FFFF, '0);
    send_word(CMD_READ, WORD_FEN_HI, '0, '0);
    send_word(CMD_TICK, 6'd0, '0, '1);
    send_word(CMD_WRITE, WORD_LEV_LO, '0, '0);
    send_word(CMD_READ, WORD_LEV_HI, '0, '0);
    send_word(CMD_READ, WORD_EDS_LO, '0, '0);
    send_word(CMD_WRITE, WORD_EDS_LO, 32'hFFFF_FFFF, '0);
    send_word(CMD_TICK, 6'd0, '0, '0);
    send_word(CMD_WRITE, WORD_HEN_HI, 32'h0020_0000, '0);
    send_word(CMD_WRITE, WORD_LEN_LO, 32'h0000_0001, '0);
    send_word(CMD_TICK, 6'd0, '0, 64'h0020_0000_0000_0000);
    send_word(CMD_NOP, 6'd63, 32'hFFFF_FFFF, '1);
    send_word(CMD_WRITE, 6'd44, 32'hFFFF_FFFF, '0);
    send_word(CMD_READ, 6'd63, '0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 500) calm = 1'b1;
      if (n == 800) calm = 1'b0;
      if (n == 1000) hold_cycles = 200;
      if (n == 1200) drain();
      random_word();
    end
    drain();
    repeat (4) @(negedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/gbed_pkg.sv
rtl/core/gbed_core.sv
rtl/core/gpio_bank_with_event_detect.sv
tb/tb_top.sv
